[rtl/qkr_pkg.sv]
// package: word types and command and status codes for the keyed-removal queue
`default_nettype none

package qkr_pkg;

  localparam int PLATE_BITS = 24;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [PLATE_BITS-1:0] plate;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PLATE_BITS-1:0] plate_res;
    logic                  last;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/qkr_ram.sv]
// single-port-write, single-port-read key store with registered read data
`default_nettype none

module qkr_ram #(
  parameter int DEPTH     = 16,
  parameter int WIDTH     = 24,
  parameter int ADDR_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/queue_with_keyed_removal.sv]
// top level: ordered key queue with insert, remove-by-key and list commands
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+------------------------------------
//  input    | start, busy, in_word        | word taken when start && !busy
//  result   | out_valid, out_word         | one-cycle strobe, no back-pressure
//
// insert: result in the next cycle, ready again at once.
// remove: the key store is scanned up to the match and then compacted one entry
// per cycle.
// list: one word per cycle with no gaps.
// reset: synchronous, clears occupancy and control; no clearing pass.
// the receiver cannot stall, so busy depends only on the command in progress.
`default_nettype none

module queue_with_keyed_removal #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire qkr_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output qkr_pkg::out_word_t      out_word
);

  import qkr_pkg::*;

  localparam int KW = (KEY_BITS < PLATE_BITS) ? KEY_BITS : PLATE_BITS;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_LIST
  } state_t;

  state_t        state_r, state_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [KW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [KW-1:0] mem_rdata;

  logic [KW-1:0] key_in;
  logic [OW-1:0] idx_w;
  logic [OW-1:0] idx_inc;
  logic [OW-1:0] idx_inc2;
  logic [OW-1:0] occ_last;

  assign key_in   = in_word.plate[KW-1:0];
  assign idx_w    = OW'(idx_r);
  assign idx_inc  = idx_w + OW'(1);
  assign idx_inc2 = idx_w + OW'(2);
  assign occ_last = occ_r - OW'(1);

  qkr_ram #(
    .DEPTH    (DEPTH),
    .WIDTH    (KW),
    .ADDR_BITS(AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = key_in;
          case (in_word.kind)
            KIND_INSERT: begin
              out_valid_nxt          = 1'b1;
              out_word_nxt.plate_res = PLATE_BITS'(key_in);
              out_word_nxt.last      = 1'b1;
              if (occ_r >= OW'(DEPTH)) begin
                out_word_nxt.status = ST_FULL;
              end else begin
                out_word_nxt.status = ST_OK;
                mem_we    = 1'b1;
                mem_waddr = AW'(occ_r);
                mem_wdata = key_in;
                occ_nxt   = occ_r + OW'(1);
              end
            end
            KIND_REMOVE: begin
              if (occ_r == '0) begin
                out_valid_nxt          = 1'b1;
                out_word_nxt.status    = ST_NOT_FOUND;
                out_word_nxt.plate_res = PLATE_BITS'(key_in);
                out_word_nxt.last      = 1'b1;
              end else begin
                mem_re    = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            KIND_LIST: begin
              if (occ_r == '0) begin
                out_valid_nxt          = 1'b1;
                out_word_nxt.status    = ST_EMPTY;
                out_word_nxt.plate_res = '0;
                out_word_nxt.last      = 1'b1;
              end else begin
                mem_re    = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end

      S_SEARCH: begin
        // read data is the entry at idx_r
        if (mem_rdata == key_r) begin
          if (idx_w == occ_last) begin
            occ_nxt                = occ_r - OW'(1);
            out_valid_nxt          = 1'b1;
            out_word_nxt.status    = ST_OK;
            out_word_nxt.plate_res = PLATE_BITS'(key_r);
            out_word_nxt.last      = 1'b1;
            state_nxt              = S_IDLE;
          end else begin
            // fetch the follower; idx_r becomes the write slot
            mem_re    = 1'b1;
            mem_raddr = AW'(idx_inc);
            state_nxt = S_SHIFT;
          end
        end else if (idx_w == occ_last) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.status    = ST_NOT_FOUND;
          out_word_nxt.plate_res = PLATE_BITS'(key_r);
          out_word_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_inc);
          idx_nxt   = AW'(idx_inc);
        end
      end

      S_SHIFT: begin
        // move entry idx_r + 1 up into idx_r
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        if (idx_inc == occ_last) begin
          occ_nxt                = occ_r - OW'(1);
          out_valid_nxt          = 1'b1;
          out_word_nxt.status    = ST_OK;
          out_word_nxt.plate_res = PLATE_BITS'(key_r);
          out_word_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_inc2);
          idx_nxt   = AW'(idx_inc);
        end
      end

      S_LIST: begin
        out_valid_nxt          = 1'b1;
        out_word_nxt.status    = ST_OK;
        out_word_nxt.plate_res = PLATE_BITS'(mem_rdata);
        out_word_nxt.last      = (idx_w == occ_last);
        if (idx_w == occ_last) begin
          state_nxt = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_inc);
          idx_nxt   = AW'(idx_inc);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

[rtl/qkr_chk.sv]
// port-level checks for the keyed-removal queue, bound to the top level
`default_nettype none

module qkr_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire qkr_pkg::in_word_t  in_word,
  input wire logic               out_valid,
  input wire qkr_pkg::out_word_t out_word
);

  import qkr_pkg::*;

  // a result only follows an accepted word or a command in progress
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a command");

  // the final word of a command leaves the block ready
  a_last_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last) |-> !busy)
    else $error("busy after final word");

  // a list streams without gaps
  a_list_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last) |=> out_valid)
    else $error("gap in listed words");

  // busy only drops together with the final word
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_word.last))
    else $error("command ended without final word");

  // insert answers in the next cycle
  a_insert_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.kind == KIND_INSERT) |=> (out_valid && out_word.last && !busy))
    else $error("insert not answered in one cycle");

endmodule

bind queue_with_keyed_removal qkr_chk u_qkr_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_word (out_word)
);

`default_nettype wire
